// File: hw/rtl/llcds_pkg.sv
// shared types, codes and constants for the lock led command and drag scroll unit
package llcds_pkg;

  localparam int InDataW  = 40;
  localparam int InUserW  = 2;
  localparam int OutDataW = 56;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int DpiW     = 2;
  localparam int DpiOptions = 4;

  typedef enum logic [1:0] {
    OpMotion = 2'd0,
    OpLed    = 2'd1,
    OpTick   = 2'd2
  } op_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegWindowTicks = 3'd0,
    RegXThreshold  = 3'd1,
    RegYThreshold  = 3'd2,
    RegCpi0        = 3'd3,
    RegCpi1        = 3'd4,
    RegCpi2        = 3'd5,
    RegCpi3        = 3'd6
  } reg_idx_e;

  localparam logic [2:0] CmdScroll    = 3'b001;
  localparam logic [2:0] CmdDpi       = 3'b010;
  localparam logic [2:0] CmdReset     = 3'b011;
  localparam logic [2:0] CmdScrollAlt = 3'b100;

  localparam logic [7:0]  WindowTicksRst = 8'd25;
  localparam logic [6:0]  XThresholdRst  = 7'd60;
  localparam logic [6:0]  YThresholdRst  = 7'd15;
  localparam logic [15:0] Cpi0Rst        = 16'd400;
  localparam logic [15:0] Cpi1Rst        = 16'd800;
  localparam logic [15:0] Cpi2Rst        = 16'd1200;
  localparam logic [15:0] Cpi3Rst        = 16'd2400;

  localparam logic signed [8:0] SatMax = 9'sd127;
  localparam logic signed [8:0] SatMin = -9'sd127;

  function automatic logic signed [7:0] sat127(input logic signed [8:0] v);
    logic signed [7:0] r;
    if (v > SatMax) begin
      r = 8'sd127;
    end else if (v < SatMin) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/lock_led_command_and_drag_scroll_unit.sv
// top level: lock led command window, dpi stepping and drag scroll
//
// channel   dir  payload
// s_axis    in   tuser: op[1:0]; tdata: motion_x, motion_y, wheel_h, wheel_v, led bits
// m_axis    out  tdata: out_x, out_y, out_h, out_v, status bits, cpi_value
// cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, write only
//
// one beat per cycle while results are taken; each beat waits in the input register
// and is resolved into the result register once that register is free or being read
// all event state updates in the single step from input to result register
// reset clears state and restores register defaults, no clearing pass
// a stalled result holds the input register full; ready drops only when both are full
module lock_led_command_and_drag_scroll_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // x[7:0] y[15:8] h[23:16] v[31:24] num[32] caps[33] scroll[34] pad
  input  logic [llcds_pkg::InDataW-1:0]     s_axis_tdata_i,
  // op[1:0]
  input  logic [llcds_pkg::InUserW-1:0]     s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // x[7:0] y[15:8] h[23:16] v[31:24] scroll_active[32] dpi_index[34:33]
  // cpi_value[50:35] cpi_changed[51] reset_request[52] window_open[53] pad
  output logic [llcds_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [llcds_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [llcds_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import llcds_pkg::*;

  // config registers
  logic [7:0]  win_ticks_q;
  logic [6:0]  x_thr_q, y_thr_q;
  logic [15:0] cpi_q [DpiOptions];

  // input register
  logic                 in_valid_q;
  logic [InDataW-1:0]   in_data_q;
  logic [InUserW-1:0]   in_user_q;

  // result register
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q, out_data_d;

  // event state
  logic            scroll_q, scroll_d;
  logic [2:0]      shadow_q, shadow_d;
  logic            win_q, win_d;
  logic [7:0]      timer_q, timer_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [2:0]      tog_q, tog_d;
  logic signed [7:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [DpiW-1:0] dpi_q, dpi_d;

  logic fire;
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ticks_q <= WindowTicksRst;
      x_thr_q     <= XThresholdRst;
      y_thr_q     <= YThresholdRst;
      cpi_q[0]    <= Cpi0Rst;
      cpi_q[1]    <= Cpi1Rst;
      cpi_q[2]    <= Cpi2Rst;
      cpi_q[3]    <= Cpi3Rst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegWindowTicks: win_ticks_q <= cfg_wdata_i[7:0];
        RegXThreshold:  x_thr_q     <= cfg_wdata_i[6:0];
        RegYThreshold:  y_thr_q     <= cfg_wdata_i[6:0];
        RegCpi0:        cpi_q[0]    <= cfg_wdata_i;
        RegCpi1:        cpi_q[1]    <= cfg_wdata_i;
        RegCpi2:        cpi_q[2]    <= cfg_wdata_i;
        RegCpi3:        cpi_q[3]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  // decoded fields of the held beat
  logic signed [7:0] mx, my, wh, wv;
  logic [2:0]        leds, changed;
  logic signed [8:0] sum_x, sum_y, xt, yt;
  logic signed [7:0] sat_x, sat_y;
  logic signed [7:0] ox, oy, oh, ov;
  logic              cpi_chg, rst_req;

  assign mx   = in_data_q[7:0];
  assign my   = in_data_q[15:8];
  assign wh   = in_data_q[23:16];
  assign wv   = in_data_q[31:24];
  assign leds = in_data_q[34:32];
  assign changed = leds ^ shadow_q;
  assign sum_x = 9'(acc_x_q) + 9'(mx);
  assign sum_y = 9'(acc_y_q) + 9'(my);
  assign sat_x = sat127(sum_x);
  assign sat_y = sat127(sum_y);
  assign xt    = $signed({2'b00, x_thr_q});
  assign yt    = $signed({2'b00, y_thr_q});

  always_comb begin
    scroll_d = scroll_q;
    shadow_d = shadow_q;
    win_d    = win_q;
    timer_d  = timer_q;
    cmd_d    = cmd_q;
    tog_d    = tog_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    dpi_d    = dpi_q;
    ox = '0;
    oy = '0;
    oh = '0;
    ov = '0;
    cpi_chg = 1'b0;
    rst_req = 1'b0;
    case (in_user_q)
      OpMotion: begin
        ox = mx;
        oy = my;
        oh = wh;
        ov = wv;
        if (scroll_q) begin
          acc_x_d = sat_x;
          acc_y_d = sat_y;
          if (9'(sat_x) > xt) begin
            oh = 8'sd1;
            acc_x_d = '0;
          end else if (9'(sat_x) < -xt) begin
            oh = -8'sd1;
            acc_x_d = '0;
          end
          if (9'(sat_y) > yt) begin
            ov = -8'sd1;
            acc_y_d = '0;
          end else if (9'(sat_y) < -yt) begin
            ov = 8'sd1;
            acc_y_d = '0;
          end
          ox = '0;
          oy = '0;
        end
      end
      OpLed: begin
        if (!win_q) begin
          win_d   = 1'b1;
          timer_d = win_ticks_q;
        end
        cmd_d    = cmd_q | (changed & tog_q);
        tog_d    = tog_q ^ changed;
        shadow_d = leds;
      end
      OpTick: begin
        if (win_q) begin
          if (timer_q <= 8'd1) begin
            case (cmd_q)
              CmdScroll, CmdScrollAlt: scroll_d = !scroll_q;
              CmdDpi: begin
                dpi_d   = (dpi_q == DpiW'(DpiOptions - 1)) ? '0 : dpi_q + 1'b1;
                cpi_chg = 1'b1;
              end
              CmdReset: rst_req = 1'b1;
              default: ;
            endcase
            cmd_d   = '0;
            tog_d   = '0;
            win_d   = 1'b0;
            timer_d = '0;
          end else begin
            timer_d = timer_q - 8'd1;
          end
        end
      end
      default: ;
    endcase
    out_data_d = {2'b00, win_d, rst_req, cpi_chg, cpi_q[dpi_d], dpi_d, scroll_d,
                  ov, oh, oy, ox};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      scroll_q    <= 1'b0;
      shadow_q    <= '0;
      win_q       <= 1'b0;
      timer_q     <= '0;
      cmd_q       <= '0;
      tog_q       <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      dpi_q       <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        scroll_q    <= scroll_d;
        shadow_q    <= shadow_d;
        win_q       <= win_d;
        timer_q     <= timer_d;
        cmd_q       <= cmd_d;
        tog_q       <= tog_d;
        acc_x_q     <= acc_x_d;
        acc_y_q     <= acc_y_d;
        dpi_q       <= dpi_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  // closed window carries no pending command or toggle
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_q |-> (cmd_q == '0) && (tog_q == '0))
    else $error("command bits pending with window closed");

  // expiring tick closes the window
  a_expire_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_user_q == OpTick) && win_q && (timer_q <= 8'd1) |=> !win_q)
    else $error("window still open after expiry");

  // state moves only when a beat is resolved
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(scroll_q) && $stable(dpi_q) && $stable(win_q))
    else $error("event state changed without a beat");

  // a result never reports both a dpi step and a reset
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[51] && out_data_q[52]))
    else $error("two commands in one result");

  // a stalled result keeps the held input beat
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |=> in_valid_q)
    else $error("input beat lost under stall");

endmodule

// File: sim/llcds_checker.sv
// checker for the lock led command and drag scroll unit: event predictor and result compare
module llcds_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [llcds_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [llcds_pkg::InUserW-1:0]  s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [llcds_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                           cfg_we_i,
  input  logic [llcds_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [llcds_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import llcds_pkg::*;

  localparam int MaxReported = 10;

  // fields from the lowest bit up: x, y, h, v, scroll, dpi, cpi, cpi_changed, reset_req, window
  typedef struct packed {
    logic        win_open;
    logic        rst_req;
    logic        cpi_chg;
    logic [15:0] cpi;
    logic [1:0]  dpi;
    logic        scroll;
    logic [7:0]  v;
    logic [7:0]  h;
    logic [7:0]  y;
    logic [7:0]  x;
  } report_t;

  logic        scroll_on;
  logic [2:0]  lock_shadow;
  logic        win_active;
  logic [7:0]  win_timer;
  logic [2:0]  cmd_bits;
  logic [2:0]  toggles;
  int          acc_x;
  int          acc_y;
  logic [1:0]  dpi;
  logic [7:0]  win_len;
  logic [6:0]  x_thr;
  logic [6:0]  y_thr;
  logic [15:0] cpi_tab [DpiOptions];

  report_t expected_reports[$];
  int      failures;
  int      results_seen;

  function automatic int clamp_pm127(input int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic string report_str(input report_t r);
    return $sformatf("x=%0d y=%0d h=%0d v=%0d scroll=%0b dpi=%0d cpi=%0d chg=%0b rst=%0b win=%0b",
                     $signed(r.x), $signed(r.y), $signed(r.h), $signed(r.v), r.scroll,
                     r.dpi, r.cpi, r.cpi_chg, r.rst_req, r.win_open);
  endfunction

  function automatic report_t predict_event(input logic [1:0] op, input logic [InDataW-1:0] d);
    report_t    r;
    logic [2:0] leds;
    logic [2:0] flips;
    r = '0;
    case (op)
      OpMotion: begin
        r.x = d[7:0];
        r.y = d[15:8];
        r.h = d[23:16];
        r.v = d[31:24];
        if (scroll_on) begin
          acc_x = clamp_pm127(acc_x + int'($signed(d[7:0])));
          acc_y = clamp_pm127(acc_y + int'($signed(d[15:8])));
          if (acc_x > int'(x_thr)) begin
            r.h = 8'h01;
            acc_x = 0;
          end else if (acc_x < -int'(x_thr)) begin
            r.h = 8'hFF;
            acc_x = 0;
          end
          // vertical wheel runs opposite to y
          if (acc_y > int'(y_thr)) begin
            r.v = 8'hFF;
            acc_y = 0;
          end else if (acc_y < -int'(y_thr)) begin
            r.v = 8'h01;
            acc_y = 0;
          end
          r.x = '0;
          r.y = '0;
        end
      end
      OpLed: begin
        r = '0;
        leds = d[34:32];
        flips = leds ^ lock_shadow;
        if (!win_active) begin
          win_active = 1'b1;
          win_timer = win_len;
        end
        cmd_bits = cmd_bits | (flips & toggles);
        toggles = toggles ^ flips;
        lock_shadow = leds;
      end
      OpTick: begin
        if (win_active) begin
          if (win_timer <= 8'd1) begin
            case (cmd_bits)
              CmdScroll, CmdScrollAlt: scroll_on = ~scroll_on;
              CmdDpi: begin
                dpi = 2'((dpi + 1) % DpiOptions);
                r.cpi_chg = 1'b1;
              end
              CmdReset: r.rst_req = 1'b1;
              default: begin
              end
            endcase
            cmd_bits = '0;
            toggles = '0;
            win_active = 1'b0;
            win_timer = '0;
          end else begin
            win_timer = win_timer - 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
    r.scroll = scroll_on;
    r.dpi = dpi;
    r.cpi = cpi_tab[dpi];
    r.win_open = win_active;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      scroll_on = 1'b0;
      lock_shadow = '0;
      win_active = 1'b0;
      win_timer = '0;
      cmd_bits = '0;
      toggles = '0;
      acc_x = 0;
      acc_y = 0;
      dpi = '0;
      win_len = WindowTicksRst;
      x_thr = XThresholdRst;
      y_thr = YThresholdRst;
      cpi_tab[0] = Cpi0Rst;
      cpi_tab[1] = Cpi1Rst;
      cpi_tab[2] = Cpi2Rst;
      cpi_tab[3] = Cpi3Rst;
      expected_reports.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          RegWindowTicks: win_len = cfg_wdata_i[7:0];
          RegXThreshold:  x_thr = cfg_wdata_i[6:0];
          RegYThreshold:  y_thr = cfg_wdata_i[6:0];
          RegCpi0:        cpi_tab[0] = cfg_wdata_i;
          RegCpi1:        cpi_tab[1] = cfg_wdata_i;
          RegCpi2:        cpi_tab[2] = cfg_wdata_i;
          RegCpi3:        cpi_tab[3] = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = report_t'(m_tdata_i[$bits(report_t)-1:0]);
        results_seen++;
        if (expected_reports.size() == 0) begin
          failures++;
          if (failures <= MaxReported) begin
            $display("result beat %0d with nothing expected: %s", results_seen, report_str(got));
          end
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= MaxReported) begin
              $display("result beat %0d mismatch", results_seen);
              $display("  expected %s", report_str(want));
              $display("  actual   %s", report_str(got));
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_reports.push_back(predict_event(s_tuser_i, s_tdata_i));
      end
    end
    fail_count_o = failures;
    pending_o = expected_reports.size();
  end

endmodule

// File: sim/tb_lock_led_command_and_drag_scroll_unit.sv
// testbench top for the lock led command and drag scroll unit: stimulus, idling and verdict
module tb_lock_led_command_and_drag_scroll_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import llcds_pkg::*;

  localparam realtime ClkHalf       = 4.0;
  localparam int      WatchdogLimit = 4000;
  localparam int      DrainCycles   = 8;
  localparam logic [1:0] OpSpare    = 2'd3;
  localparam logic [2:0] LedNum     = 3'b001;
  localparam logic [2:0] LedCaps    = 3'b010;
  localparam logic [2:0] LedScroll  = 3'b100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int                  fail_count;
  int                  pending;

  int         idle_pct = 0;
  int         stall_pct = 0;
  int         sent_count = 0;
  int         quiet_cycles = 0;
  int         tick_len = 1;
  logic [2:0] host_leds = '0;

  lock_led_command_and_drag_scroll_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  llcds_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // word holds x, y, h, v from the lowest byte up
  task automatic send_event(input logic [1:0] op, input logic [31:0] word, input logic [2:0] leds);
    logic [InDataW-1:0] d;
    bit                 rdy;
    d = '0;
    d[31:0] = word;
    d[34:32] = leds;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do begin
      @(negedge clk_i);
      rdy = s_tready;
      @(posedge clk_i);
    end while (!rdy);
    sent_count++;
  endtask

  function automatic logic [31:0] motion_word();
    logic [31:0] w;
    w = $urandom;
    // small steps so the accumulators build up over several beats
    if ($urandom_range(1)) begin
      w[7:0] = 8'($urandom_range(40)) - 8'd20;
      w[15:8] = 8'($urandom_range(40)) - 8'd20;
    end
    return w;
  endfunction

  task automatic send_motion();
    send_event(OpMotion, motion_word(), 3'($urandom));
  endtask

  task automatic send_tick();
    send_event(OpTick, $urandom, 3'($urandom));
  endtask

  task automatic set_leds(input logic [2:0] leds);
    send_event(OpLed, $urandom, leds);
    host_leds = leds;
  endtask

  task automatic toggle_twice(input logic [2:0] mask);
    set_leds(host_leds ^ mask);
    set_leds(host_leds ^ mask);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] wt, input logic [6:0] xt, input logic [6:0] yt,
                              input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3);
    wait_drain();
    write_reg(RegWindowTicks, 16'(wt));
    write_reg(RegXThreshold, 16'(xt));
    write_reg(RegYThreshold, 16'(yt));
    write_reg(RegCpi0, c0);
    write_reg(RegCpi1, c1);
    write_reg(RegCpi2, c2);
    write_reg(RegCpi3, c3);
    cfg_we <= 1'b0;
    tick_len = (wt <= 8'd1) ? 1 : int'(wt);
  endtask

  task automatic command_episode(input logic [2:0] cmd);
    int ticks;
    if ($urandom_range(1)) begin
      set_leds(host_leds ^ cmd);
      repeat ($urandom_range(3)) send_motion();
      set_leds(host_leds ^ cmd);
    end else begin
      if (cmd == '0) set_leds(host_leds);
      if ((cmd & LedNum) != '0) toggle_twice(LedNum);
      if ((cmd & LedCaps) != '0) toggle_twice(LedCaps);
      if ((cmd & LedScroll) != '0) toggle_twice(LedScroll);
    end
    repeat ($urandom_range(3)) send_motion();
    // now and then the window is left open into the next sequence
    ticks = ($urandom_range(9) == 0) ? tick_len - 1 : tick_len;
    repeat (ticks) begin
      send_tick();
      if ($urandom_range(3) == 0) send_motion();
    end
    repeat ($urandom_range(2, 12)) send_motion();
  endtask

  task automatic noise_burst();
    logic [1:0] op;
    repeat ($urandom_range(4, 16)) begin
      op = 2'($urandom_range(3));
      if (op == OpLed) begin
        set_leds(3'($urandom));
      end else if (op == OpMotion) begin
        send_motion();
      end else begin
        send_event(op, $urandom, 3'($urandom));
      end
    end
    repeat (tick_len) send_tick();
  endtask

  task automatic run_phase(input int items, input int idle, input int stall,
                           input logic [7:0] wt, input logic [6:0] xt, input logic [6:0] yt,
                           input logic [15:0] c0, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [15:0] c3, input bit hold_off);
    int         stop_at;
    int         pick;
    logic [2:0] cmd;
    program_regs(wt, xt, yt, c0, c1, c2, c3);
    idle_pct = idle;
    stall_pct = stall;
    stop_at = sent_count + items;
    while (sent_count < stop_at) begin
      if (hold_off && sent_count >= stop_at - items / 2) begin
        wait_drain();
        hold_off = 1'b0;
      end
      if ($urandom_range(99) < 75) begin
        pick = $urandom_range(9);
        if (pick < 4) cmd = pick[0] ? CmdScroll : CmdScrollAlt;
        else if (pick < 6) cmd = CmdDpi;
        else if (pick < 7) cmd = CmdReset;
        else cmd = 3'($urandom);
        command_episode(cmd);
      end else begin
        noise_burst();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(8'd1, 7'd0, 7'd127, 16'd0, 16'hFFFF, 16'h5A5A, 16'hA5A5);
    send_event(OpMotion, 32'h7F81807F, LedNum);
    send_event(OpMotion, 32'h807F7F80, LedCaps);
    send_event(OpSpare, 32'hFFFFFFFF, 3'b111);
    send_tick();
    toggle_twice(LedNum);
    send_tick();
    send_event(OpMotion, 32'h0000807F, 3'b000);
    send_event(OpMotion, 32'h00008080, 3'b000);
    send_event(OpMotion, 32'h12340000, 3'b000);
    toggle_twice(LedCaps);
    send_tick();
    toggle_twice(LedNum | LedCaps);
    send_tick();
    toggle_twice(LedScroll);
    send_tick();
    toggle_twice(LedNum | LedCaps | LedScroll);
    send_tick();
    send_event(OpMotion, 32'hFF0180FF, 3'b000);

    run_phase(260, 0, 0, 8'd3, XThresholdRst, YThresholdRst,
              Cpi0Rst, Cpi1Rst, Cpi2Rst, Cpi3Rst, 1'b0);
    run_phase(260, 73, 0, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(300, 0, 73, 8'd255, 7'd127, 7'd127,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(260, 12, 12, 8'd1, 7'($urandom), 7'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    run_phase(260, 0, 0, 8'($urandom_range(2, 6)), 7'($urandom_range(30)),
              7'($urandom_range(30)), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 1'b1);
    run_phase(200, 73, 0, 8'd2, 7'd5, 7'd5,
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/llcds_pkg.sv
hw/rtl/lock_led_command_and_drag_scroll_unit.sv
sim/llcds_checker.sv
sim/tb_lock_led_command_and_drag_scroll_unit.sv
